[rtl/tdem_pkg.sv]
// shared types and constants of the triangle diffusion element matrix
package tdem_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int MAG_W      = PROD_W + 1;
    localparam int FRAC_SHIFT = 19;
    localparam int QUO_W      = 33;
    localparam int REM_W      = MAG_W + QUO_W;
    localparam int ENTRY_W    = 32;
    localparam int LANES      = 6;
    localparam int SIDE_W     = LANES + 1;

    // unique (row, col) pairs of the symmetric matrix
    localparam logic [1:0] LANE_ROW [LANES] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] LANE_COL [LANES] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    typedef struct packed {
        logic signed [COORD_W-1:0] vert0_x;
        logic signed [COORD_W-1:0] vert1_x;
        logic signed [COORD_W-1:0] vert2_x;
        logic signed [COORD_W-1:0] vert0_y;
        logic signed [COORD_W-1:0] vert1_y;
        logic signed [COORD_W-1:0] vert2_y;
    } t_tdem_in;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] entry_00;
        logic signed [ENTRY_W-1:0] entry_01;
        logic signed [ENTRY_W-1:0] entry_02;
        logic signed [ENTRY_W-1:0] entry_10;
        logic signed [ENTRY_W-1:0] entry_11;
        logic signed [ENTRY_W-1:0] entry_12;
        logic signed [ENTRY_W-1:0] entry_20;
        logic signed [ENTRY_W-1:0] entry_21;
        logic signed [ENTRY_W-1:0] entry_22;
        logic                      degenerate;
    } t_tdem_out;

endpackage

[rtl/tdem_div.sv]
// six-lane pipelined restoring divider, one quotient bit per stage, rounded
module tdem_div
    import tdem_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [MAG_W-1:0]         i_num [LANES],
    input  logic [MAG_W-1:0]         i_den,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [QUO_W:0]           o_quo [LANES],
    output logic [LANES-1:0]         o_ovf,
    output logic [SIDE_W-1:0]        o_side
);

    localparam int NST = QUO_W + 2;

    logic [REM_W-1:0]  r_rem  [0:QUO_W][LANES];
    logic [QUO_W-1:0]  r_quo  [0:QUO_W][LANES];
    logic [LANES-1:0]  r_ovf  [0:QUO_W];
    logic [MAG_W-1:0]  r_den  [0:QUO_W];
    logic [SIDE_W-1:0] r_side [0:QUO_W];
    logic [NST-1:0]    r_v;
    logic [NST:0]      w_acc;

    logic [QUO_W:0]    r_qo [LANES];
    logic [LANES-1:0]  r_ovfo;
    logic [SIDE_W-1:0] r_sideo;

    assign w_acc[NST] = !i_stall;
    for (genvar s = 0; s < NST; s++) begin : g_acc
        assign w_acc[s] = !r_v[s] || w_acc[s+1];
    end
    assign o_stall = !w_acc[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < NST; s++) begin
                if (w_acc[s]) begin
                    r_v[s] <= (s == 0) ? i_valid : r_v[s-1];
                end
            end
        end
    end

    // entry stage: scale numerator, flag quotients too big for the bit count
    for (genvar l = 0; l < LANES; l++) begin : g_in
        always_ff @(posedge i_clk) begin
            if (w_acc[0]) begin
                r_rem[0][l] <= REM_W'({i_num[l], {FRAC_SHIFT{1'b0}}});
                r_quo[0][l] <= '0;
                r_ovf[0][l] <= REM_W'({i_num[l], {FRAC_SHIFT{1'b0}}})
                               >= REM_W'({i_den, {QUO_W{1'b0}}});
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_acc[0]) begin
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [REM_W:0] w_dif;
            assign w_dif = {1'b0, r_rem[s-1][l]}
                         - ({1'b0, REM_W'(r_den[s-1])} << (QUO_W - s));
            always_ff @(posedge i_clk) begin
                if (w_acc[s]) begin
                    r_rem[s][l] <= w_dif[REM_W] ? r_rem[s-1][l] : w_dif[REM_W-1:0];
                    r_quo[s][l] <= {r_quo[s-1][l][QUO_W-2:0], !w_dif[REM_W]};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_acc[s]) begin
                r_ovf[s]  <= r_ovf[s-1];
                r_den[s]  <= r_den[s-1];
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // round half away from zero on the magnitude
    for (genvar l = 0; l < LANES; l++) begin : g_rnd
        always_ff @(posedge i_clk) begin
            if (w_acc[NST-1]) begin
                r_qo[l] <= {1'b0, r_quo[QUO_W][l]}
                         + (QUO_W+1)'({r_rem[QUO_W][l], 1'b0} >= (REM_W+1)'(r_den[QUO_W]));
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_acc[NST-1]) begin
            r_ovfo  <= r_ovf[QUO_W];
            r_sideo <= r_side[QUO_W];
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_quo   = r_qo;
    assign o_ovf   = r_ovfo;
    assign o_side  = r_sideo;

endmodule

[rtl/tri3_diffusion_element_matrix.sv]
// Diffusion element matrix of a linear triangle: takes three vertex coordinate pairs
// (signed Q16.16) and returns the symmetric 3x3 matrix (signed Q13.19, rounded half
// away from zero, saturated) with a degenerate flag that zeroes every entry when the
// determinant is zero. Fully pipelined: one item per cycle unless stalled, over three
// front stages for differences, products and sums, 35 stages of the six-lane
// pipelined divider and one saturation/output register. A stall backs up only as far
// as the pipeline holds bubbles, so items keep entering while results wait.
module tri3_diffusion_element_matrix
    import tdem_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_tdem_in  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_tdem_out o_item
);

    logic signed [DIFF_W-1:0] r_b [3];
    logic signed [DIFF_W-1:0] r_c [3];
    logic signed [DIFF_W-1:0] r_dx01, r_dy02;
    logic signed [PROD_W-1:0] r_pa, r_pb;
    logic signed [PROD_W-1:0] r_bb [LANES];
    logic signed [PROD_W-1:0] r_cc [LANES];
    logic [MAG_W-1:0]         r_num [LANES];
    logic [MAG_W-1:0]         r_den;
    logic [SIDE_W-1:0]        r_side;
    logic [2:0]               r_v;
    logic [3:0]               w_acc;
    logic                     div_stall, div_valid;
    logic [QUO_W:0]           div_quo [LANES];
    logic [LANES-1:0]         div_ovf;
    logic [SIDE_W-1:0]        div_side;
    logic signed [ENTRY_W-1:0] w_ent [LANES];
    t_tdem_out                r_out;
    logic                     r_vo;
    logic                     w_acc_o;

    logic signed [MAG_W-1:0]  w_det;
    logic signed [MAG_W-1:0]  w_num [LANES];

    assign w_acc_o  = !r_vo || !i_stall;
    assign w_acc[3] = !div_stall;
    assign w_acc[2] = !r_v[2] || w_acc[3];
    assign w_acc[1] = !r_v[1] || w_acc[2];
    assign w_acc[0] = !r_v[0] || w_acc[1];
    assign o_stall  = !w_acc[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vo <= 1'b0;
        end else begin
            if (w_acc[0]) r_v[0] <= i_valid;
            if (w_acc[1]) r_v[1] <= r_v[0];
            if (w_acc[2]) r_v[2] <= r_v[1];
            if (w_acc_o)  r_vo   <= div_valid;
        end
    end

    // edge differences
    always_ff @(posedge i_clk) begin
        if (w_acc[0]) begin
            r_b[0] <= DIFF_W'(i_item.vert1_y) - DIFF_W'(i_item.vert2_y);
            r_b[1] <= DIFF_W'(i_item.vert2_y) - DIFF_W'(i_item.vert0_y);
            r_b[2] <= DIFF_W'(i_item.vert0_y) - DIFF_W'(i_item.vert1_y);
            r_c[0] <= DIFF_W'(i_item.vert2_x) - DIFF_W'(i_item.vert1_x);
            r_c[1] <= DIFF_W'(i_item.vert0_x) - DIFF_W'(i_item.vert2_x);
            r_c[2] <= DIFF_W'(i_item.vert1_x) - DIFF_W'(i_item.vert0_x);
            r_dx01 <= DIFF_W'(i_item.vert0_x) - DIFF_W'(i_item.vert1_x);
            r_dy02 <= DIFF_W'(i_item.vert0_y) - DIFF_W'(i_item.vert2_y);
        end
    end

    // products
    for (genvar l = 0; l < LANES; l++) begin : g_prod
        always_ff @(posedge i_clk) begin
            if (w_acc[1]) begin
                r_bb[l] <= r_b[LANE_ROW[l]] * r_b[LANE_COL[l]];
                r_cc[l] <= r_c[LANE_ROW[l]] * r_c[LANE_COL[l]];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_acc[1]) begin
            r_pa <= r_dx01 * r_dy02;
            r_pb <= r_c[1] * r_b[2];
        end
    end

    // sums, magnitudes and signs
    assign w_det = MAG_W'(r_pa) - MAG_W'(r_pb);
    for (genvar l = 0; l < LANES; l++) begin : g_sum
        assign w_num[l] = MAG_W'(r_bb[l]) + MAG_W'(r_cc[l]);
        always_ff @(posedge i_clk) begin
            if (w_acc[2]) begin
                r_num[l]  <= w_num[l][MAG_W-1] ? MAG_W'(-w_num[l]) : MAG_W'(w_num[l]);
                r_side[l] <= w_num[l][MAG_W-1] ^ w_det[MAG_W-1];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_acc[2]) begin
            r_den          <= w_det[MAG_W-1] ? MAG_W'(-w_det) : MAG_W'(w_det);
            r_side[LANES]  <= (w_det == '0);
        end
    end

    tdem_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[2]),
        .o_stall (div_stall),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  (r_side),
        .o_valid (div_valid),
        .i_stall (!w_acc_o),
        .o_quo   (div_quo),
        .o_ovf   (div_ovf),
        .o_side  (div_side)
    );

    // sign and saturation
    for (genvar l = 0; l < LANES; l++) begin : g_sat
        logic [QUO_W:0] w_negq;
        assign w_negq = '0 - div_quo[l];
        always_comb begin
            if (div_side[LANES]) begin
                w_ent[l] = '0;
            end else if (div_side[l]) begin
                if (div_ovf[l] || div_quo[l] > (QUO_W+1)'({1'b1, {(ENTRY_W-1){1'b0}}}))
                    w_ent[l] = {1'b1, {(ENTRY_W-1){1'b0}}};
                else
                    w_ent[l] = w_negq[ENTRY_W-1:0];
            end else begin
                if (div_ovf[l] || div_quo[l] > (QUO_W+1)'({1'b0, {(ENTRY_W-1){1'b1}}}))
                    w_ent[l] = {1'b0, {(ENTRY_W-1){1'b1}}};
                else
                    w_ent[l] = div_quo[l][ENTRY_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_o) begin
            r_out.entry_00   <= w_ent[0];
            r_out.entry_01   <= w_ent[1];
            r_out.entry_02   <= w_ent[2];
            r_out.entry_10   <= w_ent[1];
            r_out.entry_11   <= w_ent[3];
            r_out.entry_12   <= w_ent[4];
            r_out.entry_20   <= w_ent[2];
            r_out.entry_21   <= w_ent[4];
            r_out.entry_22   <= w_ent[5];
            r_out.degenerate <= div_side[LANES];
        end
    end

    assign o_valid = r_vo;
    assign o_item  = r_out;

endmodule

[rtl/tdem_checker.sv]
// port-level checks of the element matrix block, bound to the top level
module tdem_checker
    import tdem_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_stall,
    input t_tdem_out o_item
);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled item changed");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.degenerate |->
            o_item.entry_00 == 0 && o_item.entry_01 == 0 && o_item.entry_02 == 0 &&
            o_item.entry_10 == 0 && o_item.entry_11 == 0 && o_item.entry_12 == 0 &&
            o_item.entry_20 == 0 && o_item.entry_21 == 0 && o_item.entry_22 == 0)
        else $error("degenerate item with nonzero entry");

    a_symmetric: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.entry_01 == o_item.entry_10 &&
                    o_item.entry_02 == o_item.entry_20 &&
                    o_item.entry_12 == o_item.entry_21)
        else $error("matrix not symmetric");

endmodule

bind tri3_diffusion_element_matrix tdem_checker u_tdem_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);
